// ----- design/siq_pkg.sv -----
package siq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_POP    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  popped_value;
		logic [1:0]                status;
		logic signed [DATA_W-1:0]  head_value;
		logic                      not_empty;
		logic [4:0]                entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic rsp_busy;
	} sts_t;

endpackage

// ----- design/siq_ctrl.sv -----
module siq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic          rsp_stall,
	input  siq_pkg::sts_t sts,
	output siq_pkg::cmd_t cmd
);
	import siq_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_nx    = S_UPD;
			end
			S_UPD: begin
				// result register must be free or emptying this cycle
				if (!sts.rsp_busy || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/siq_dpath.sv -----
module siq_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  siq_pkg::req_t req_data,
	input  siq_pkg::cmd_t cmd,
	output siq_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output siq_pkg::rsp_t rsp_data
);
	import siq_pkg::*;

	logic signed [DATA_W-1:0] entries_q [DEPTH];
	logic signed [DATA_W-1:0] entries_nx [DEPTH];
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_nx;
	logic [1:0]               mode_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]         pos_q;
	logic [CNT_W-1:0]         pos_cmp;
	logic [DEPTH-1:0]         ge_vec;
	logic [IDX_W-1:0]         tail_idx;
	logic                     tail_le;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	rsp_t                     rsp_nx;
	logic                     full;
	logic                     is_push;
	logic                     do_push;
	logic                     do_pop;

	// compare phase: every slot against the new value in parallel
	always_comb begin
		tail_idx = IDX_W'(cnt_q - CNT_W'(1));
		tail_le  = (val_q >= entries_q[tail_idx]);
		for (int i = 0; i < DEPTH; i++) begin
			ge_vec[i] = (entries_q[i] >= val_q);
		end
		pos_cmp = cnt_q;
		if (mode_q == MODE_INSERT && cnt_q != '0 && !tail_le) begin
			for (int i = DEPTH - 1; i >= 0; i--) begin
				if (ge_vec[i]) begin
					pos_cmp = CNT_W'(i);
				end
			end
		end
	end

	// update phase: shift toward tail on push, toward head on pop
	always_comb begin
		full    = (cnt_q == CNT_W'(DEPTH));
		is_push = (mode_q == MODE_APPEND) || (mode_q == MODE_INSERT);
		do_push = is_push && !full;
		do_pop  = (mode_q == MODE_POP) && (cnt_q != '0);
		cnt_nx  = cnt_q;
		for (int i = 0; i < DEPTH; i++) begin
			entries_nx[i] = entries_q[i];
		end
		if (do_push) begin
			cnt_nx = cnt_q + CNT_W'(1);
			for (int i = 0; i < DEPTH; i++) begin
				if (CNT_W'(i) == pos_q) begin
					entries_nx[i] = val_q;
				end else if (i > 0 && CNT_W'(i) > pos_q && CNT_W'(i) <= cnt_q) begin
					entries_nx[i] = entries_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (do_pop) begin
			cnt_nx = cnt_q - CNT_W'(1);
			for (int i = 0; i < DEPTH - 1; i++) begin
				entries_nx[i] = entries_q[i + 1];
			end
		end

		rsp_nx.popped_value = do_pop ? entries_q[0] : '0;
		rsp_nx.status       = ST_OK;
		if (is_push && full) begin
			rsp_nx.status = ST_FULL;
		end else if (mode_q == MODE_POP && cnt_q == '0) begin
			rsp_nx.status = ST_EMPTY;
		end
		rsp_nx.not_empty   = (cnt_nx != '0);
		rsp_nx.head_value  = (cnt_nx != '0) ? entries_nx[0] : '0;
		rsp_nx.entry_count = 5'(cnt_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q       <= cnt_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_data.mode;
			val_q  <= req_data.value;
		end
		if (cmd.compare) begin
			pos_q <= pos_cmp;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_nx;
			for (int i = 0; i < DEPTH; i++) begin
				entries_q[i] <= entries_nx[i];
			end
		end
	end

	assign sts.rsp_busy = rsp_valid_q;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

endmodule

// ----- design/sorted_insert_queue.sv -----
// A request transaction passes load, compare and commit before response valid is set;
// commit waits only while the previous response is still held by rsp_stall.
// No new request is taken until the previous one commits (compare-then-shift sequence).
// Reset: arst_n clears the entry count, the controller state and response valid;
// entry storage is not cleared, slots at or above the count never affect a result.
module sorted_insert_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  siq_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output siq_pkg::rsp_t rsp_data
);
	import siq_pkg::*;

	// Controller sequences each request transaction:
	//   IDLE  take the request into the datapath
	//   CMP   compare all slots with the value, register insert position
	//   UPD   shift entries, update count, load the response register
	// The response register decouples the two sides: a new request is
	// taken while the last response is still waiting downstream.
	cmd_t cmd;
	sts_t sts;

	siq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: slot registers, parallel compare, shift network and
	// the response register.
	siq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule
